[rtl/pat_pkg.sv]
// Shared types, constants and the multiply schedule of the polyline angle thinning block.
package pat_pkg;

  // Coordinate width and the widths that follow from it.
  localparam int CoordBits = 16;
  localparam int DiffW     = CoordBits + 1;               // segment component
  localparam int SqW       = 2 * DiffW;                   // squared segment length
  localparam int DotW      = 2 * DiffW + 1;               // signed dot product
  localparam int MulW      = (DotW > 32) ? DotW : 32;     // shared multiplier operand
  localparam int ProdW     = 4 * CoordBits + 3;           // |a|^2 * |b|^2 and dot^2
  localparam int SplitW    = MulW - 1;                    // low part of ProdW for t^2 product
  localparam int HiW       = ProdW - SplitW;

  // Threshold register and its derived widths (signed fixed point Q2.15).
  localparam int ThrW      = 17;
  localparam int ThrFrac   = 15;
  localparam int ThrSqW    = 2 * ThrFrac + 1;             // clamped threshold squared
  localparam int RhsW      = ProdW + 2 * ThrFrac;         // both sides of the final compare
  localparam logic signed [ThrW-1:0] ThrOne    = 17'sd32768;
  localparam logic signed [ThrW-1:0] ThrNegOne = -17'sd32768;

  // Configuration register indexes.
  localparam int CfgAddrW  = 2;
  localparam logic [CfgAddrW-3+1:0] RegCosThreshold = 1'b0;

  // Count of points held for the current shape.
  localparam logic [1:0] SeenNone = 2'd0;
  localparam logic [1:0] SeenOne  = 2'd1;
  localparam logic [1:0] SeenTwo  = 2'd2;

  // Length of the multiply schedule for one middle point.
  localparam int MathSteps = 12;
  localparam int StepW     = $clog2(MathSteps);

  typedef struct packed {
    logic signed [CoordBits-1:0] pt_x;
    logic signed [CoordBits-1:0] pt_y;
    logic                        end_of_shape;
  } pt_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] out_x;
    logic signed [CoordBits-1:0] out_y;
    logic                        out_last;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATH,
    ST_MID,
    ST_FIN
  } ctrl_state_e;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_AXAX,
    MUL_AYAY,
    MUL_BXBX,
    MUL_BYBY,
    MUL_AXBX,
    MUL_AYBY,
    MUL_LALB,
    MUL_TT,
    MUL_DOTDOT,
    MUL_TLO,
    MUL_THI
  } mul_sel_e;

  typedef enum logic [3:0] {
    ACC_NONE,
    ACC_LA_SET,
    ACC_LA_ADD,
    ACC_LB_SET,
    ACC_LB_ADD,
    ACC_DOT_SET,
    ACC_DOT_ADD,
    ACC_PROD_SET,
    ACC_T2_SET,
    ACC_LHS_SET,
    ACC_RHS_SET,
    ACC_RHS_ADD
  } acc_sel_e;

  typedef enum logic [1:0] {
    PUSH_NONE,
    PUSH_MID,
    PUSH_CUR
  } push_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    mul_sel_e  mul_sel;
    acc_sel_e  acc_sel;
    logic      load_in;
    push_sel_e push;
    logic      advance;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic seen_two;
    logic cur_needed;
    logic keep;
    logic out_free;
  } sts_t;

  // Multiply schedule. Each step issues at most one product and folds the product
  // of the previous step, if there is one, into its destination register.
  function automatic cmd_t math_cmd(input logic [StepW-1:0] step);
    cmd_t c;
    c.mul_sel = MUL_NONE;
    c.acc_sel = ACC_NONE;
    c.load_in = 1'b0;
    c.push    = PUSH_NONE;
    c.advance = 1'b0;
    case (step)
      4'd0: begin
        c.mul_sel = MUL_AXAX;
      end
      4'd1: begin
        c.mul_sel = MUL_AYAY;
        c.acc_sel = ACC_LA_SET;
      end
      4'd2: begin
        c.mul_sel = MUL_BXBX;
        c.acc_sel = ACC_LA_ADD;
      end
      4'd3: begin
        c.mul_sel = MUL_BYBY;
        c.acc_sel = ACC_LB_SET;
      end
      4'd4: begin
        c.mul_sel = MUL_AXBX;
        c.acc_sel = ACC_LB_ADD;
      end
      4'd5: begin
        c.mul_sel = MUL_LALB;
        c.acc_sel = ACC_DOT_SET;
      end
      4'd6: begin
        c.mul_sel = MUL_AYBY;
        c.acc_sel = ACC_PROD_SET;
      end
      4'd7: begin
        c.mul_sel = MUL_TT;
        c.acc_sel = ACC_DOT_ADD;
      end
      4'd8: begin
        c.mul_sel = MUL_DOTDOT;
        c.acc_sel = ACC_T2_SET;
      end
      4'd9: begin
        c.mul_sel = MUL_TLO;
        c.acc_sel = ACC_LHS_SET;
      end
      4'd10: begin
        c.mul_sel = MUL_THI;
        c.acc_sel = ACC_RHS_SET;
      end
      4'd11: begin
        c.acc_sel = ACC_RHS_ADD;
      end
      default: begin
        c.mul_sel = MUL_NONE;
      end
    endcase
    return c;
  endfunction

endpackage

[rtl/pat_ctrl.sv]
// Controller state machine that sequences one point through the datapath.
module pat_ctrl
  import pat_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  cmd_t step_cmd;

  // Commands of the current multiply step.
  assign step_cmd = math_cmd(step_q);

  // State and step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    in_ready_o    = 1'b0;
    cmd_o.mul_sel = MUL_NONE;
    cmd_o.acc_sel = ACC_NONE;
    cmd_o.load_in = 1'b0;
    cmd_o.push    = PUSH_NONE;
    cmd_o.advance = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          step_d        = '0;
          // Only a point with two predecessors needs the angle test.
          state_d       = sts_i.seen_two ? ST_MATH : ST_FIN;
        end
      end
      ST_MATH: begin
        cmd_o.mul_sel = step_cmd.mul_sel;
        cmd_o.acc_sel = step_cmd.acc_sel;
        step_d        = step_q + 1'b1;
        if (step_q == StepW'(MathSteps - 1)) begin
          state_d = ST_MID;
        end
      end
      ST_MID: begin
        // The middle point goes out only if it turns sharply enough.
        if (!sts_i.keep) begin
          state_d = ST_FIN;
        end else if (sts_i.out_free) begin
          cmd_o.push = PUSH_MID;
          state_d    = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!sts_i.cur_needed) begin
          cmd_o.advance = 1'b1;
          state_d       = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.push    = PUSH_CUR;
          cmd_o.advance = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/pat_datapath.sv]
// Datapath: point history, shared multiplier, angle compare and output register.
module pat_datapath
  import pat_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  pt_t                    in_item_i,
  output res_t                   out_item_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  logic                   cfg_we_i,
  input  logic [ThrW-1:0]        cfg_wdata_i,
  output logic signed [ThrW-1:0] cfg_rdata_o
);

  // Shape history and the point being worked on.
  logic signed [CoordBits-1:0] before_x_q, before_y_q, middle_x_q, middle_y_q;
  logic [1:0]                  seen_q;
  pt_t                         cur_q;
  logic signed [ThrW-1:0]      thr_q;

  // Arithmetic registers.
  logic signed [2*MulW-1:0] p_q, p_d;
  logic [SqW-1:0]           la2_q, lb2_q;
  logic signed [DotW-1:0]   dot_q;
  logic [ProdW-1:0]         prod_q;
  logic [ThrSqW-1:0]        t2_q;
  logic [ProdW-1:0]         lhs_q;
  logic [RhsW-1:0]          rhs_q;

  // Output register.
  res_t out_q;
  logic out_valid_q;

  logic signed [DiffW-1:0] ax, ay, bx, by;
  logic signed [ThrW-1:0]  tc;
  logic signed [MulW-1:0]  a_op, b_op;
  logic [RhsW-1:0]         p_ext, lhs_sh;
  logic                    out_free, dot_neg, t_pos, t_neg, keep;

  // Segment components from the original neighbors.
  assign ax = DiffW'(middle_x_q) - DiffW'(before_x_q);
  assign ay = DiffW'(middle_y_q) - DiffW'(before_y_q);
  assign bx = DiffW'(cur_q.pt_x) - DiffW'(middle_x_q);
  assign by = DiffW'(cur_q.pt_y) - DiffW'(middle_y_q);

  // Threshold clamped to the range of a cosine.
  always_comb begin
    if (thr_q > ThrOne) begin
      tc = ThrOne;
    end else if (thr_q < ThrNegOne) begin
      tc = ThrNegOne;
    end else begin
      tc = thr_q;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    a_op = '0;
    b_op = '0;
    case (cmd_i.mul_sel)
      MUL_AXAX: begin
        a_op = MulW'(ax);
        b_op = MulW'(ax);
      end
      MUL_AYAY: begin
        a_op = MulW'(ay);
        b_op = MulW'(ay);
      end
      MUL_BXBX: begin
        a_op = MulW'(bx);
        b_op = MulW'(bx);
      end
      MUL_BYBY: begin
        a_op = MulW'(by);
        b_op = MulW'(by);
      end
      MUL_AXBX: begin
        a_op = MulW'(ax);
        b_op = MulW'(bx);
      end
      MUL_AYBY: begin
        a_op = MulW'(ay);
        b_op = MulW'(by);
      end
      MUL_LALB: begin
        a_op = MulW'(la2_q);
        b_op = MulW'(lb2_q);
      end
      MUL_TT: begin
        a_op = MulW'(tc);
        b_op = MulW'(tc);
      end
      MUL_DOTDOT: begin
        a_op = MulW'(dot_q);
        b_op = MulW'(dot_q);
      end
      MUL_TLO: begin
        a_op = MulW'(t2_q);
        b_op = MulW'(prod_q[SplitW-1:0]);
      end
      MUL_THI: begin
        a_op = MulW'(t2_q);
        b_op = MulW'(prod_q[ProdW-1:SplitW]);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign p_d   = a_op * b_op;
  assign p_ext = RhsW'($unsigned(p_q));

  // Product register and accumulation of the previous product.
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    case (cmd_i.acc_sel)
      ACC_LA_SET:   la2_q  <= p_q[SqW-1:0];
      ACC_LA_ADD:   la2_q  <= la2_q + p_q[SqW-1:0];
      ACC_LB_SET:   lb2_q  <= p_q[SqW-1:0];
      ACC_LB_ADD:   lb2_q  <= lb2_q + p_q[SqW-1:0];
      ACC_DOT_SET:  dot_q  <= p_q[DotW-1:0];
      ACC_DOT_ADD:  dot_q  <= dot_q + p_q[DotW-1:0];
      ACC_PROD_SET: prod_q <= p_q[ProdW-1:0];
      ACC_T2_SET:   t2_q   <= p_q[ThrSqW-1:0];
      ACC_LHS_SET:  lhs_q  <= p_q[ProdW-1:0];
      ACC_RHS_SET:  rhs_q  <= p_ext;
      ACC_RHS_ADD:  rhs_q  <= rhs_q + (p_ext << SplitW);
      default: begin
        rhs_q <= rhs_q;
      end
    endcase
  end

  // Turn test: compare dot^2 * 2^30 against t^2 * |a|^2 * |b|^2 with signs apart.
  assign lhs_sh  = {lhs_q, {(2 * ThrFrac){1'b0}}};
  assign dot_neg = dot_q[DotW-1];
  assign t_pos   = (tc > 0);
  assign t_neg   = tc[ThrW-1];

  always_comb begin
    if ((la2_q == '0) || (lb2_q == '0)) begin
      keep = 1'b0;
    end else if (dot_neg) begin
      keep = t_neg ? (lhs_sh > rhs_q) : 1'b1;
    end else begin
      keep = t_pos ? (lhs_sh < rhs_q) : 1'b0;
    end
  end

  // Input capture and shape history update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      before_x_q <= '0;
      before_y_q <= '0;
      middle_x_q <= '0;
      middle_y_q <= '0;
      seen_q     <= SeenNone;
    end else if (cmd_i.advance) begin
      if (cur_q.end_of_shape) begin
        seen_q <= SeenNone;
      end else if (seen_q == SeenNone) begin
        middle_x_q <= cur_q.pt_x;
        middle_y_q <= cur_q.pt_y;
        seen_q     <= SeenOne;
      end else begin
        before_x_q <= middle_x_q;
        before_y_q <= middle_y_q;
        middle_x_q <= cur_q.pt_x;
        middle_y_q <= cur_q.pt_y;
        seen_q     <= SeenTwo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cur_q <= in_item_i;
    end
  end

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrOne;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Output register; it is free when empty or being taken.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push != PUSH_NONE) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.push)
      PUSH_MID: begin
        out_q.out_x    <= middle_x_q;
        out_q.out_y    <= middle_y_q;
        out_q.out_last <= 1'b0;
      end
      PUSH_CUR: begin
        out_q.out_x    <= cur_q.pt_x;
        out_q.out_y    <= cur_q.pt_y;
        out_q.out_last <= cur_q.end_of_shape;
      end
      default: begin
        out_q <= out_q;
      end
    endcase
  end

  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;
  assign cfg_rdata_o = thr_q;

  // Status to the controller.
  assign sts_o.seen_two   = (seen_q == SeenTwo);
  assign sts_o.cur_needed = (seen_q == SeenNone) || cur_q.end_of_shape;
  assign sts_o.keep       = keep;
  assign sts_o.out_free   = out_free;

endmodule

[rtl/polyline_angle_thinning.sv]
// Top level of the polyline angle thinning block: controller, datapath and register port.
// A first point of a shape, or a second one that ends it, goes from idle to the finish
// state, which pushes it into the output register; no new item is taken before idle.
// A later point runs 12 steps of the shared 35x35 multiplier, then the middle-point state
// and the finish state, either of which output stalls can hold, before the next item.
// Reset clears the shape history and output valid and sets the threshold to 1.0.
module polyline_angle_thinning
  import pat_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pt_t                 in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output res_t                out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cmd_t                   cmd;
  sts_t                   sts;
  logic                   in_ready;
  logic                   cfg_we;
  logic signed [ThrW-1:0] cfg_rdata;

  // Register port: a single register, always ready.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr == CfgAddrW'({RegCosThreshold, 2'b00}));
  assign prdata = 32'(cfg_rdata);

  assign in_stall_o = !in_ready;

  pat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pat_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata[ThrW-1:0]),
    .cfg_rdata_o (cfg_rdata)
  );

  // An accepted item keeps the input stalled on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted on two consecutive cycles");

  // A result is only pushed into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.push != PUSH_NONE) |-> sts.out_free)
    else $error("result pushed over a waiting result");

  // The multiplier runs only while an item is being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.mul_sel != MUL_NONE) |-> in_stall_o)
    else $error("multiplier active while input is open");

endmodule

[bench/testbench.sv]
// Self-checking testbench of the polyline angle thinning block with its own point predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pat_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int SettleWait  = 40;
  localparam int PhaseItems  = 36;

  logic clk_i;
  logic rst_ni = 1'b0;

  // Stimulus side of the point stream.
  logic in_valid = 1'b0;
  logic in_stall;
  pt_t  in_item = '0;

  // Receiving side of the kept-point stream.
  logic out_valid;
  logic out_stall = 1'b0;
  res_t out_item;

  // Register port.
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [CfgAddrW-1:0] paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Points waiting to be sent and kept points waiting to be seen.
  pt_t  point_queue[$];
  res_t kept_points[$];

  // Predictor copy of the shape history and the threshold register.
  logic signed [CoordBits-1:0] prev_x = '0;
  logic signed [CoordBits-1:0] prev_y = '0;
  logic signed [CoordBits-1:0] mid_x  = '0;
  logic signed [CoordBits-1:0] mid_y  = '0;
  logic [1:0]                  held   = SeenNone;
  logic signed [ThrW-1:0]      thr    = ThrOne;

  bit idle_on     = 1'b1;
  int error_count = 0;
  int cycle_count = 0;
  int send_gap    = 0;
  int hold_cnt    = 0;

  polyline_angle_thinning DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Append a point to the send queue.
  function automatic void queue_point(pt_t p);
    point_queue.insert(point_queue.size(), p);
  endfunction

  // Append a kept point to the list of results still to come.
  function automatic void add_kept_point(res_t r);
    kept_points.insert(kept_points.size(), r);
  endfunction

  // True when the turn between segments a and b is sharper than the threshold allows.
  // Both sides of cos < t are squared in wide unsigned arithmetic, signs handled apart.
  function automatic bit turn_is_sharp(longint ax, longint ay, longint bx, longint by);
    longint       t;
    longint       dot;
    logic [127:0] la2;
    logic [127:0] lb2;
    logic [127:0] adot;
    logic [127:0] at;
    logic [127:0] lhs;
    logic [127:0] rhs;
    t = longint'(thr);
    if (t > longint'(ThrOne)) t = longint'(ThrOne);
    if (t < longint'(ThrNegOne)) t = longint'(ThrNegOne);
    la2 = 128'(ax * ax + ay * ay);
    lb2 = 128'(bx * bx + by * by);
    // A zero-length segment means no turn at all.
    if (la2 == 0 || lb2 == 0) return 1'b0;
    dot = ax * bx + ay * by;
    if (dot >= 0 && t <= 0) return 1'b0;
    if (dot < 0 && t >= 0) return 1'b1;
    adot = 128'((dot < 0) ? -dot : dot);
    at   = 128'((t < 0) ? -t : t);
    lhs  = (adot * adot) << 30;
    rhs  = at * at * la2 * lb2;
    return (dot >= 0) ? (lhs < rhs) : (lhs > rhs);
  endfunction

  // Work out the kept points that one accepted point releases.
  function automatic void predict_kept_points(pt_t p);
    res_t r;
    if (held == SeenNone) begin
      r.out_x    = p.pt_x;
      r.out_y    = p.pt_y;
      r.out_last = p.end_of_shape;
      add_kept_point(r);
      if (!p.end_of_shape) begin
        mid_x = p.pt_x;
        mid_y = p.pt_y;
        held  = SeenOne;
      end
      return;
    end
    // The pending middle point is judged against its original neighbors.
    if (held == SeenTwo &&
        turn_is_sharp(longint'(mid_x) - longint'(prev_x), longint'(mid_y) - longint'(prev_y),
                      longint'(p.pt_x) - longint'(mid_x), longint'(p.pt_y) - longint'(mid_y)))
    begin
      r.out_x    = mid_x;
      r.out_y    = mid_y;
      r.out_last = 1'b0;
      add_kept_point(r);
    end
    if (p.end_of_shape) begin
      r.out_x    = p.pt_x;
      r.out_y    = p.pt_y;
      r.out_last = 1'b1;
      add_kept_point(r);
      held = SeenNone;
    end else begin
      prev_x = mid_x;
      prev_y = mid_y;
      mid_x  = p.pt_x;
      mid_y  = p.pt_y;
      held   = SeenTwo;
    end
  endfunction

  function automatic pt_t make_point(logic signed [CoordBits-1:0] x,
                                     logic signed [CoordBits-1:0] y, bit last);
    pt_t p;
    p.pt_x         = x;
    p.pt_y         = y;
    p.end_of_shape = last;
    return p;
  endfunction

  // Driver: present queued points, hold each until accepted, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) predict_kept_points(in_item);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (point_queue.size() > 0) begin
          in_item  <= point_queue.pop_front();
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(3) == 0) send_gap = $urandom_range(15, 1);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted kept point and stall the output in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_pt;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (kept_points.size() == 0) begin
          $display("%0t: expected no kept point, got x=%0d y=%0d last=%0d", $realtime,
                   out_item.out_x, out_item.out_y, out_item.out_last);
          error_count++;
        end else begin
          exp_pt = kept_points.pop_front();
          if (out_item.out_x !== exp_pt.out_x || out_item.out_y !== exp_pt.out_y ||
              out_item.out_last !== exp_pt.out_last) begin
            $display("%0t: mismatch, expected x=%0d y=%0d last=%0d, got x=%0d y=%0d last=%0d",
                     $realtime, exp_pt.out_x, exp_pt.out_y, exp_pt.out_last,
                     out_item.out_x, out_item.out_y, out_item.out_last);
            error_count++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(7) == 0) begin
        hold_cnt = $urandom_range(14, 0);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Wait until every point is sent and every kept point seen, then let the block drain.
  task automatic settle();
    while (point_queue.size() > 0 || in_valid || kept_points.size() > 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  // One register access: setup cycle, then access cycle until pready.
  task automatic reg_access(input logic write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= CfgAddrW'(4 * RegCosThreshold);
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write the threshold, update the predictor copy and read the register back.
  task automatic set_threshold(int value);
    logic [31:0] rdata;
    reg_access(1'b1, 32'(value), rdata);
    thr = ThrW'(value);
    reg_access(1'b0, '0, rdata);
    if (rdata[ThrW-1:0] !== thr) begin
      $display("%0t: threshold readback mismatch, expected %0d, got %0d", $realtime,
               thr, $signed(rdata[ThrW-1:0]));
      error_count++;
    end
  endtask

  // Queue one shape of random length in one of several styles.
  task automatic queue_random_shape(output int n);
    int                          style;
    int                          dx;
    int                          dy;
    int                          swap;
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    n     = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(12, 3);
    style = $urandom_range(4);
    x     = CoordBits'($urandom);
    y     = CoordBits'($urandom);
    dx    = int'($urandom_range(600)) - 300;
    dy    = int'($urandom_range(600)) - 300;
    for (int i = 0; i < n; i++) begin
      queue_point(make_point(x, y, i == n - 1));
      case (style)
        // Unrelated points anywhere in the plane.
        0: begin
          x = CoordBits'($urandom);
          y = CoordBits'($urandom);
        end
        // Tiny steps: many repeated and collinear points.
        1: begin
          x += CoordBits'(int'($urandom_range(2)) - 1);
          y += CoordBits'(int'($urandom_range(2)) - 1);
        end
        // Nearly straight line with jitter, close to the threshold.
        2: begin
          x += CoordBits'(dx + int'($urandom_range(6)) - 3);
          y += CoordBits'(dy + int'($urandom_range(6)) - 3);
        end
        // Right-angle turns and reversals now and then.
        3: begin
          x += CoordBits'(dx);
          y += CoordBits'(dy);
          if ($urandom_range(2) == 0) begin
            swap = dx;
            dx   = -dy;
            dy   = swap;
          end else if ($urandom_range(3) == 0) begin
            dx = -dx;
            dy = -dy;
          end
        end
        // Slowly bending curve.
        default: begin
          x  += CoordBits'(dx);
          y  += CoordBits'(dy);
          dx += int'($urandom_range(40)) - 20;
          dy += int'($urandom_range(40)) - 20;
        end
      endcase
    end
  endtask

  initial begin
    int thresholds[];
    int queued;
    int n;
    thresholds = '{0, -32768, 23170, 65535, -65536, -16384, 32440, 40000, 30000, 32768};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed shapes at the reset threshold of 1.0.
    // Single point at the coordinate extremes.
    queue_point(make_point(-16'sd32768, 16'sd32767, 1'b1));
    // Two-point shape.
    queue_point(make_point(16'sd32767, -16'sd32768, 1'b0));
    queue_point(make_point(16'sd0, 16'sd0, 1'b1));
    // Exactly straight: the middle point goes.
    queue_point(make_point(16'sd0, 16'sd0, 1'b0));
    queue_point(make_point(16'sd1, 16'sd1, 1'b0));
    queue_point(make_point(16'sd2, 16'sd2, 1'b1));
    // Zero-length incoming segment.
    queue_point(make_point(16'sd5, 16'sd5, 1'b0));
    queue_point(make_point(16'sd5, 16'sd5, 1'b0));
    queue_point(make_point(16'sd9, 16'sd9, 1'b1));
    // Full reversal, then a right angle and a jump to the far corner.
    queue_point(make_point(16'sd0, 16'sd0, 1'b0));
    queue_point(make_point(16'sd100, 16'sd0, 1'b0));
    queue_point(make_point(16'sd0, 16'sd0, 1'b0));
    queue_point(make_point(16'sd0, 16'sd100, 1'b0));
    queue_point(make_point(-16'sd32768, -16'sd32768, 1'b1));
    // Widest segments the coordinates allow.
    queue_point(make_point(-16'sd32768, -16'sd32768, 1'b0));
    queue_point(make_point(16'sd32767, 16'sd32767, 1'b0));
    queue_point(make_point(-16'sd32768, 16'sd32767, 1'b0));
    queue_point(make_point(16'sd32767, -16'sd32768, 1'b1));
    settle();

    // Random shapes over a sweep of thresholds, extremes and out-of-range values included.
    foreach (thresholds[k]) begin
      set_threshold(thresholds[k]);
      idle_on = (k != thresholds.size() - 1) && ($urandom_range(3) != 0);
      queued  = 0;
      while (queued < PhaseItems) begin
        queue_random_shape(n);
        queued += n;
      end
      settle();
    end

    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
